// ----- src/spdo_pkg.sv -----
// package for the safety pdo consumer monitor
// action codes, error codes, record type and controller states; no dependencies
package spdo_pkg;

  localparam int unsigned NumConnectionsDefault = 16;

  typedef enum logic [2:0] {
    ACT_RESET   = 3'd0,
    ACT_SYNC_OK = 3'd1,
    ACT_FRAME   = 3'd2,
    ACT_TIMEOUT = 3'd3,
    ACT_SYNC_NG = 3'd4,
    ACT_COUNT   = 3'd5,
    ACT_STATUS  = 3'd6,
    ACT_UNUSED  = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TIMER     = 2'd1,
    ERR_TOO_SHORT = 2'd2,
    ERR_TOO_LONG  = 2'd3
  } err_t;

  localparam int unsigned RegControlTime = 0;
  localparam int unsigned RegMinDelay    = 1;
  localparam int unsigned RegMaxDelay    = 2;

  localparam logic [15:0] HalfRange16 = 16'h8000;

  typedef struct packed {
    logic        safe_flag;
    logic        count_check_on;
    logic [15:0] last_count;
    logic        synced;
    logic [15:0] cons_reference;
    logic [15:0] prod_reference;
    logic [15:0] stored_sync_delay;
    logic [31:0] deadline;
    logic [15:0] prod_delta;
    logic        conn_valid;
  } rec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT
  } state_t;

endpackage

// ----- src/safety_pdo_consumer_monitor.sv -----
// top level of the safety pdo consumer monitor: record memory, action logic, output register
// depends on spdo_pkg
//
//  channel | valid     | stall      | payload
//  in      | in_valid  | in_stall   | action .. sync_delay
//  out     | out_valid | out_stall  | to_defaults .. last_sync_delay
//  cfg     | cfg_we    | -          | cfg_index, cfg_data
//
// an item is accepted, then its connection record is read from the single-port record
// memory, then the record is modified, written back and the output register loaded;
// the result is loaded at the writeback, which waits while the output register is stalled.
// an item is taken while the previous result waits in the output register.
// reset marks every record invalid; an invalid record reads as all zeros with the safe flag set.
// a stalled output register holds; the next item's writeback waits until it is free.
module safety_pdo_consumer_monitor #(
  parameter int unsigned NUM_CONNECTIONS = spdo_pkg::NumConnectionsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [3:0]  connection,
  input  logic [31:0] now_time,
  input  logic [15:0] frame_count,
  input  logic        frame_conn_flag,
  input  logic        payload_fits,
  input  logic [15:0] consumer_ref,
  input  logic [15:0] producer_ref,
  input  logic [15:0] sync_delay,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        to_defaults,
  output logic        data_taken,
  output logic        in_safe_state,
  output logic        sync_good,
  output logic        link_valid,
  output logic [1:0]  error_code,
  output logic [15:0] measured_delay,
  output logic        count_ok,
  output logic        status_valid,
  output logic [15:0] producer_delta,
  output logic [31:0] data_age,
  output logic [15:0] last_sync_delay
);
  import spdo_pkg::*;

  localparam int unsigned AW = (NUM_CONNECTIONS > 1) ? $clog2(NUM_CONNECTIONS) : 1;

  logic [15:0] control_time, min_delay, max_delay;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_time <= '0;
      min_delay    <= '0;
      max_delay    <= 16'hffff;
    end else if (cfg_we) begin
      case (cfg_index)
        2'(RegControlTime): control_time <= cfg_data;
        2'(RegMinDelay):    min_delay    <= cfg_data;
        2'(RegMaxDelay):    max_delay    <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  // captured item
  action_t     act;
  logic        in_range;
  logic [AW-1:0] addr;
  logic [31:0] now_q;
  logic [15:0] fc_q, cref_q, pref_q, sdel_q;
  logic        fflag_q, fits_q;

  rec_t mem [NUM_CONNECTIONS];
  rec_t rd_data;
  logic [NUM_CONNECTIONS-1:0] rec_ok;
  logic rd_ok;

  logic accept, wb;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign wb       = (state == ST_OUT) && !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_READ;
      ST_READ: state_next = ST_OUT;
      ST_OUT:  if (wb) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act      <= action_t'(action);
      in_range <= ({28'd0, connection} < 32'(NUM_CONNECTIONS));
      addr     <= AW'(connection);
      now_q    <= now_time;
      fc_q     <= frame_count;
      fflag_q  <= frame_conn_flag;
      fits_q   <= payload_fits;
      cref_q   <= consumer_ref;
      pref_q   <= producer_ref;
      sdel_q   <= sync_delay;
    end
  end

  rec_t rec_new;
  logic do_write;
  assign do_write = wb && in_range;

  always_ff @(posedge clk) begin
    if (state == ST_READ) rd_data <= mem[addr];
    if (do_write) mem[addr] <= rec_new;
  end

  always_ff @(posedge clk) begin
    if (rst) rec_ok <= '0;
    else if (do_write) rec_ok[addr] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) rd_ok <= rec_ok[addr];
  end

  rec_t r;
  always_comb begin
    if (rd_ok) r = rd_data;
    else begin
      r = '0;
      r.safe_flag = 1'b1;
    end
  end

  // action logic
  logic        o_def, o_taken, o_cok, o_sval;
  err_t        o_err;
  logic [15:0] o_mdel, o_pdelta, o_ldel;
  logic [31:0] o_age;
  logic [15:0] dcons, dprod, pd, fdiff;
  logic [31:0] tdiff;

  always_comb begin
    dcons = now_q[15:0] - r.cons_reference;
    dprod = fc_q - r.prod_reference;
    pd    = dcons - dprod;
    fdiff = fc_q - r.last_count;
    tdiff = now_q - r.deadline;
    rec_new  = r;
    o_def    = 1'b0;
    o_taken  = 1'b0;
    o_cok    = 1'b0;
    o_sval   = 1'b0;
    o_err    = ERR_NONE;
    o_mdel   = '0;
    o_pdelta = '0;
    o_ldel   = '0;
    o_age    = '0;
    case (act)
      ACT_RESET: begin
        rec_new.safe_flag      = 1'b1;
        rec_new.count_check_on = 1'b0;
        rec_new.last_count     = '0;
        rec_new.synced         = 1'b0;
        rec_new.cons_reference = '0;
        rec_new.prod_reference = '0;
        rec_new.deadline       = '0;
      end
      ACT_SYNC_OK: begin
        rec_new.cons_reference    = cref_q;
        rec_new.prod_reference    = pref_q;
        rec_new.stored_sync_delay = sdel_q;
        rec_new.synced            = 1'b1;
      end
      ACT_FRAME, ACT_TIMEOUT, ACT_SYNC_NG: begin
        if (act == ACT_SYNC_NG || r.safe_flag) rec_new.conn_valid = 1'b0;
        else if (act == ACT_FRAME)             rec_new.conn_valid = fflag_q;
        if (r.safe_flag) o_def = 1'b1;
        if (act == ACT_FRAME) begin
          if (r.synced) begin
            o_mdel = pd;
            if (pd < min_delay || dprod > dcons) begin
              o_err = ERR_TOO_SHORT;
              o_def = 1'b1;
              rec_new.count_check_on = 1'b0;
              rec_new.synced         = 1'b0;
              rec_new.safe_flag      = 1'b1;
            end else if (pd <= max_delay) begin
              if (!r.count_check_on) begin
                // first frame after sync only arms the counter check
                o_def = 1'b1;
                rec_new.count_check_on = 1'b1;
                rec_new.last_count     = fc_q;
                rec_new.safe_flag      = 1'b1;
              end else if (fits_q) begin
                rec_new.prod_delta = fdiff;
                rec_new.last_count = fc_q;
                rec_new.deadline   = now_q + {16'd0, control_time};
                rec_new.safe_flag  = 1'b0;
                o_taken = 1'b1;
              end
            end else begin
              o_err = ERR_TOO_LONG;
            end
          end
        end else if (!r.safe_flag) begin
          if (act == ACT_SYNC_NG || !tdiff[31]) begin
            if (act != ACT_SYNC_NG) o_err = ERR_TIMER;
            o_def = 1'b1;
            rec_new.count_check_on = 1'b0;
            rec_new.synced         = 1'b0;
            rec_new.safe_flag      = 1'b1;
          end
        end
      end
      ACT_COUNT: begin
        o_cok = !r.count_check_on || (fc_q != r.last_count && fdiff < HalfRange16);
      end
      ACT_STATUS: begin
        if (r.synced && !r.safe_flag) begin
          o_sval   = 1'b1;
          o_pdelta = r.prod_delta;
          o_age    = now_q - (r.deadline - {16'd0, control_time});
          o_ldel   = r.stored_sync_delay;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (wb) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (wb) begin
      if (in_range) begin
        to_defaults     <= o_def;
        data_taken      <= o_taken;
        in_safe_state   <= rec_new.safe_flag;
        sync_good       <= rec_new.synced;
        link_valid      <= rec_new.conn_valid;
        error_code      <= o_err;
        measured_delay  <= o_mdel;
        count_ok        <= o_cok;
        status_valid    <= o_sval;
        producer_delta  <= o_pdelta;
        data_age        <= o_age;
        last_sync_delay <= o_ldel;
      end else begin
        to_defaults     <= 1'b0;
        data_taken      <= 1'b0;
        in_safe_state   <= 1'b0;
        sync_good       <= 1'b0;
        link_valid      <= 1'b0;
        error_code      <= ERR_NONE;
        measured_delay  <= '0;
        count_ok        <= 1'b0;
        status_valid    <= 1'b0;
        producer_delta  <= '0;
        data_age        <= '0;
        last_sync_delay <= '0;
      end
    end
  end

  // a result is loaded only at the end of an item's read-modify-write
  a_load_after_read: assert property (@(posedge clk) disable iff (rst)
    wb |-> $past(state) == ST_READ || $past(state) == ST_OUT)
    else $error("result loaded without a record read");

  // input is closed while an item is in flight
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_OUT) |-> in_stall)
    else $error("item accepted while another is in flight");

  // data taken means the record left the safe state
  a_taken_safe: assert property (@(posedge clk) disable iff (rst)
    (out_valid && data_taken) |-> !in_safe_state && error_code == ERR_NONE)
    else $error("data taken while in safe state");

endmodule

// ----- verif/tb.sv -----
// testbench for the safety pdo consumer monitor: predicts every result from a local
// copy of the connection records and compares it field by field; depends on spdo_pkg
`timescale 1ns / 100ps

module tb;
  import spdo_pkg::*;

  localparam int NCONN = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  connection;
    logic [31:0] now_time;
    logic [15:0] frame_count;
    logic        frame_conn_flag;
    logic        payload_fits;
    logic [15:0] consumer_ref;
    logic [15:0] producer_ref;
    logic [15:0] sync_delay;
  } item_t;

  typedef struct packed {
    logic        to_defaults;
    logic        data_taken;
    logic        in_safe_state;
    logic        sync_good;
    logic        link_valid;
    logic [1:0]  error_code;
    logic [15:0] measured_delay;
    logic        count_ok;
    logic        status_valid;
    logic [15:0] producer_delta;
    logic [31:0] data_age;
    logic [15:0] last_sync_delay;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  item_t cur = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  verdict_t got;

  always #5 clk = ~clk;

  safety_pdo_consumer_monitor dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(cur.action), .connection(cur.connection), .now_time(cur.now_time),
    .frame_count(cur.frame_count), .frame_conn_flag(cur.frame_conn_flag),
    .payload_fits(cur.payload_fits), .consumer_ref(cur.consumer_ref),
    .producer_ref(cur.producer_ref), .sync_delay(cur.sync_delay),
    .out_valid(out_valid), .out_stall(out_stall),
    .to_defaults(got.to_defaults), .data_taken(got.data_taken),
    .in_safe_state(got.in_safe_state), .sync_good(got.sync_good),
    .link_valid(got.link_valid), .error_code(got.error_code),
    .measured_delay(got.measured_delay), .count_ok(got.count_ok),
    .status_valid(got.status_valid), .producer_delta(got.producer_delta),
    .data_age(got.data_age), .last_sync_delay(got.last_sync_delay)
  );

  // shadow of the connection records and the limit registers
  logic [15:0] ctl_time, win_min, win_max;
  logic        m_safe[NCONN], m_armed[NCONN], m_synced[NCONN], m_link[NCONN];
  logic [15:0] m_last[NCONN], m_cref[NCONN], m_pref[NCONN], m_sdel[NCONN];
  logic [15:0] m_delta[NCONN];
  logic [31:0] m_deadline[NCONN];

  item_t    pending_items[$];
  verdict_t expected_results[$];
  int n_sent = 0, n_checked = 0, n_errors = 0, n_frames_taken = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  bit hold_off = 0;
  int in_gap = 0, out_gap = 0;
  bit acc_in = 0;
  bit gap_on = 1;

  function automatic void clear_rec(int c);
    m_safe[c] = 1; m_armed[c] = 0; m_last[c] = 0; m_synced[c] = 0;
    m_cref[c] = 0; m_pref[c] = 0; m_deadline[c] = 0;
  endfunction

  function automatic void go_safe(int c);
    m_armed[c] = 0; m_synced[c] = 0; m_safe[c] = 1;
  endfunction

  function automatic verdict_t consume_item(item_t it);
    verdict_t v;
    int c;
    logic was_safe;
    logic [15:0] dcons, dprod, pd;
    v = '0;
    c = it.connection;
    case (action_t'(it.action))
      ACT_RESET: clear_rec(c);
      ACT_SYNC_OK: begin
        m_cref[c] = it.consumer_ref; m_pref[c] = it.producer_ref;
        m_sdel[c] = it.sync_delay; m_synced[c] = 1;
      end
      ACT_FRAME, ACT_TIMEOUT, ACT_SYNC_NG: begin
        was_safe = m_safe[c];
        if (it.action == ACT_SYNC_NG || was_safe) m_link[c] = 0;
        else if (it.action == ACT_FRAME) m_link[c] = it.frame_conn_flag;
        if (was_safe) v.to_defaults = 1;
        if (it.action == ACT_FRAME) begin
          if (m_synced[c]) begin
            dcons = it.now_time[15:0] - m_cref[c];
            dprod = it.frame_count - m_pref[c];
            pd = dcons - dprod;
            v.measured_delay = pd;
            if (pd < win_min || dprod > dcons) begin
              v.error_code = ERR_TOO_SHORT; v.to_defaults = 1; go_safe(c);
            end else if (pd <= win_max) begin
              if (!m_armed[c]) begin
                v.to_defaults = 1; m_armed[c] = 1; m_last[c] = it.frame_count;
                m_safe[c] = 1;
              end else if (it.payload_fits) begin
                m_delta[c] = it.frame_count - m_last[c];
                m_last[c] = it.frame_count;
                m_deadline[c] = it.now_time + {16'd0, ctl_time};
                m_safe[c] = 0; v.data_taken = 1;
              end
            end else v.error_code = ERR_TOO_LONG;
          end
        end else if (!was_safe) begin
          if (it.action == ACT_SYNC_NG) begin
            v.to_defaults = 1; go_safe(c);
          end else if (it.now_time - m_deadline[c] < 32'h8000_0000) begin
            v.error_code = ERR_TIMER; v.to_defaults = 1; go_safe(c);
          end
        end
      end
      ACT_COUNT:
        if (!m_armed[c] || (it.frame_count != m_last[c] &&
            16'(it.frame_count - m_last[c]) < HalfRange16))
          v.count_ok = 1;
      ACT_STATUS:
        if (m_synced[c] && !m_safe[c]) begin
          v.status_valid = 1; v.producer_delta = m_delta[c];
          v.data_age = it.now_time - (m_deadline[c] - {16'd0, ctl_time});
          v.last_sync_delay = m_sdel[c];
        end
      default: ;
    endcase
    v.in_safe_state = m_safe[c];
    v.sync_good = m_synced[c];
    v.link_valid = m_link[c];
    return v;
  endfunction

  // driver: next item offered at the falling edge after a random gap
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || acc_in) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur <= pending_items.pop_front();
          in_valid <= 1'b1;
          in_gap <= gap_on ? $urandom_range(0, 16) : 0;
        end else in_valid <= 1'b0;
      end
      if (hold_off) out_stall <= 1'b1;
      else if (out_gap > 0) begin
        out_gap <= out_gap - 1; out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  // monitor: handshakes sampled at the rising edge
  always @(posedge clk) begin
    verdict_t want;
    acc_in <= 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(consume_item(cur));
        acc_in <= 1'b1;
        n_sent++;
      end
      if (out_valid && !out_stall) begin
        if (out_gap == 0 && gap_on) out_gap <= $urandom_range(0, 16);
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected item: %p", got);
        end else begin
          want = expected_results.pop_front();
          if (want.data_taken) n_frames_taken++;
          if (want !== got) begin
            n_errors++;
            if (n_errors <= 10) $display("mismatch: exp %p got %p", want, got);
          end
        end
        n_checked++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else if (in_valid || expected_results.size() > 0) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      2'(RegControlTime): ctl_time = val;
      2'(RegMinDelay):    win_min = val;
      default:            win_max = val;
    endcase
  endtask

  task automatic drain();
    while ((pending_items.size() > 0 || in_valid || expected_results.size() > 0)
           && !timed_out)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic item_t rand_item(int c, logic [2:0] act);
    item_t it;
    it.action = act;
    it.connection = 4'(c);
    it.now_time = $urandom;
    it.frame_count = 16'($urandom);
    it.frame_conn_flag = 1'($urandom);
    it.payload_fits = $urandom_range(0, 5) != 0;
    it.consumer_ref = 16'($urandom);
    it.producer_ref = 16'($urandom);
    it.sync_delay = 16'($urandom);
    return it;
  endfunction

  // well-formed life of a connection: sync, frames inside the window, checks
  task automatic queue_session(int c);
    item_t it;
    logic [31:0] t;
    logic [15:0] pc, cref, pref;
    int nf;
    t = $urandom; cref = 16'($urandom); pref = 16'($urandom); pc = pref;
    it = rand_item(c, ACT_SYNC_OK);
    it.consumer_ref = cref; it.producer_ref = pref;
    if ($urandom_range(0, 3) == 0) it.consumer_ref = t[15:0];
    pending_items.push_back(it);
    cref = it.consumer_ref;
    nf = $urandom_range(2, 8);
    for (int k = 0; k < nf; k++) begin
      t += $urandom_range(1, 3000);
      pc = pc + 16'($urandom_range(0, 2000));
      it = rand_item(c, ACT_FRAME);
      it.now_time = t;
      it.frame_count = pc;
      // keep the delay usually in the window; sometimes a random count
      if ($urandom_range(0, 7) == 0) it.frame_count = 16'($urandom);
      else begin
        it.consumer_ref = '0;
        it.frame_count = pref + (16'(t[15:0] - cref)) - 16'($urandom_range(0, 600));
        pc = it.frame_count;
      end
      pending_items.push_back(it);
      case ($urandom_range(0, 5))
        0: begin
          it = rand_item(c, ACT_COUNT);
          it.frame_count = pc + 16'($urandom_range(0, 3));
          pending_items.push_back(it);
        end
        1: begin
          it = rand_item(c, ACT_STATUS); it.now_time = t + $urandom_range(0, 500);
          pending_items.push_back(it);
        end
        2: begin
          it = rand_item(c, ACT_TIMEOUT);
          it.now_time = t + $urandom_range(0, 70000);
          pending_items.push_back(it);
        end
        default: ;
      endcase
    end
    if ($urandom_range(0, 3) == 0) pending_items.push_back(rand_item(c, ACT_SYNC_NG));
  endtask

  initial begin
    item_t it;
    ctl_time = 0; win_min = 0; win_max = 16'hFFFF;
    for (int c = 0; c < NCONN; c++) begin
      clear_rec(c); m_sdel[c] = 0; m_delta[c] = 0; m_link[c] = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: every action, extremes, safe state, unsynced frame, bad payload
    write_reg(2'(RegControlTime), 16'hFFFF);
    write_reg(2'(RegMinDelay), 16'd0);
    write_reg(2'(RegMaxDelay), 16'd1000);
    for (int a = 0; a < 8; a++) pending_items.push_back(rand_item(1, 3'(a)));
    it = rand_item(2, ACT_FRAME); pending_items.push_back(it);  // not synced
    it = '1; it.action = ACT_SYNC_OK; pending_items.push_back(it);
    it = '1; it.action = ACT_FRAME; it.payload_fits = 1; pending_items.push_back(it);
    it.frame_count = 16'hFFFE; it.now_time = 32'hFFFF_FFFE; pending_items.push_back(it);
    it = '1; it.action = ACT_FRAME; it.payload_fits = 0; pending_items.push_back(it);
    it = '0; it.action = ACT_SYNC_OK; pending_items.push_back(it);
    it = '0; it.action = ACT_FRAME; it.frame_conn_flag = 1; pending_items.push_back(it);
    it.payload_fits = 1; it.now_time = 5; it.frame_count = 3;
    pending_items.push_back(it);
    it = '0; it.action = ACT_STATUS; it.now_time = 32'hFFFF_FFFF; pending_items.push_back(it);
    it = '0; it.action = ACT_COUNT; it.frame_count = 16'h8002; pending_items.push_back(it);
    it = '0; it.action = ACT_TIMEOUT; it.now_time = 32'h8000_0000; pending_items.push_back(it);
    it = '0; it.action = ACT_TIMEOUT; pending_items.push_back(it);
    it = '0; it.action = ACT_SYNC_NG; pending_items.push_back(it);
    drain();

    // random phases over several limit settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(2'(RegControlTime), ph == 5 ? 16'd0 : 16'($urandom_range(0, 65535)));
      write_reg(2'(RegMinDelay), ph == 1 ? 16'hFFFF : 16'($urandom_range(0, 300)));
      write_reg(2'(RegMaxDelay), ph == 2 ? 16'd0 : 16'($urandom_range(400, 65535)));
      gap_on = (ph != 3);
      while (n_sent + pending_items.size() < 25 + (ph + 1) * 240) begin
        if ($urandom_range(0, 4) == 0)
          pending_items.push_back(rand_item($urandom_range(0, NCONN - 1),
                                             3'($urandom_range(0, 7))));
        else queue_session($urandom_range(0, NCONN - 1));
      end
      if (ph == 2) begin
        // long receiver hold-off while the sender keeps offering
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      drain();
    end

    if (timed_out) $display("FAILURE");
    else begin
      $display("items %0d, results checked %0d, frames taken %0d, mismatches %0d",
               n_sent, n_checked, n_frames_taken, n_errors);
      if (n_errors == 0 && expected_results.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
    end
    $finish;
  end

  // timeout path
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end
endmodule
